### src/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared widths, types and the Booth step function for the signed multiplier.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int WIDTH  = 32;         // operand width
    localparam int IN_W   = 32;         // width of each input field
    localparam int PROD_W = 64;         // width of the product field
    localparam int DATA_W = 2 * IN_W;   // packed input tdata width

    // booth recoding of {q0, guard}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

    typedef struct packed {
        logic [WIDTH-1:0] acc;    // running accumulator
        logic [WIDTH-1:0] mplr;   // multiplier / low product half
        logic             guard;  // bit shifted out of mplr last step
        logic [WIDTH-1:0] mcand;  // multiplicand, carried along
    } stage_t;

    // one radix-2 booth step: add/sub, then arithmetic shift of acc:mplr:guard
    function automatic stage_t booth_step(input stage_t cur);
        stage_t           nxt;
        logic [WIDTH-1:0] sum;
        begin
            case ({cur.mplr[0], cur.guard})
                BOOTH_SUB: sum = cur.acc - cur.mcand;
                BOOTH_ADD: sum = cur.acc + cur.mcand;
                default:   sum = cur.acc;
            endcase
            nxt.guard = cur.mplr[0];
            nxt.mplr  = {sum[0], cur.mplr[WIDTH-1:1]};
            nxt.acc   = {sum[WIDTH-1], sum[WIDTH-1:1]};
            nxt.mcand = cur.mcand;
            return nxt;
        end
    endfunction

endpackage

### src/booth_signed_multiplier.sv
// ----------------------------------------------------------------------------
// booth_signed_multiplier
// Radix-2 Booth signed multiplier, one booth step per pipeline stage.
// Stages: an operand capture register, then one register per booth step.
// Throughput: one operand pair per cycle; the whole pipeline holds on stall.
// Reset: aresetn (synchronous, active low) clears all stage valid bits.
// ----------------------------------------------------------------------------
module booth_signed_multiplier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bsm_pkg::DATA_W-1:0]    s_tdata,   // [31:0] multiplicand, [63:32] multiplier
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bsm_pkg::PROD_W-1:0]    m_tdata    // [63:0] product
);

    localparam int W = bsm_pkg::WIDTH;

    logic                 adv;
    logic [W:0]           v_reg;
    logic [W:0]           v_next;
    bsm_pkg::stage_t      stage_reg  [0:W];
    bsm_pkg::stage_t      stage_next [0:W];

    // pipeline moves unless the output holds a result that is not taken
    assign adv      = !v_reg[W] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v_reg[W];
    assign m_tdata  = bsm_pkg::PROD_W'($signed({stage_reg[W].acc, stage_reg[W].mplr}));

    always_comb begin
        v_next[0]           = s_tvalid;
        stage_next[0].acc   = '0;
        stage_next[0].guard = 1'b0;
        stage_next[0].mcand = s_tdata[W-1:0];
        stage_next[0].mplr  = s_tdata[bsm_pkg::IN_W+W-1:bsm_pkg::IN_W];
        for (int i = 1; i <= W; i++) begin
            v_next[i]     = v_reg[i-1];
            stage_next[i] = bsm_pkg::booth_step(stage_reg[i-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= W; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

endmodule

### src/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks for the booth multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module bsm_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [bsm_pkg::PROD_W-1:0] m_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // a stalled result keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // input side only stalls when the output is blocked
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind booth_signed_multiplier bsm_checker u_bsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/tb_booth_signed_multiplier.sv
// ----------------------------------------------------------------------------
// tb_booth_signed_multiplier
// Self-checking testbench for the radix-2 Booth signed multiplier. Operand
// pairs go in over the input stream and each product coming out is compared
// with a bit-level Booth model kept here. A directed pass covers the operand
// extremes and the wrap of the most negative multiplicand. Random passes then
// run under several idle mixes, and a long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb_booth_signed_multiplier;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               W = bsm_pkg::WIDTH;
    localparam logic [W-1:0]     MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]     MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]     ALL_ONES = {W{1'b1}};
    localparam int               DRAIN_CYCLES = W + 8;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [bsm_pkg::DATA_W-1:0]   s_tdata;   // [31:0] multiplicand, [63:32] multiplier
    logic                         m_tvalid;
    logic                         m_tready;
    logic [bsm_pkg::PROD_W-1:0]   m_tdata;   // [63:0] product

    logic [bsm_pkg::PROD_W-1:0]   pending_products[$];
    int                           mismatch_count = 0;
    int                           send_idle_pct  = 0;
    int                           recv_idle_pct  = 0;
    int                           hold_cycles    = 0;

    booth_signed_multiplier uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // accumulator drops its carry, so the most negative multiplicand wraps
    function automatic logic [bsm_pkg::PROD_W-1:0] booth_product(
        input logic [W-1:0] mcand,
        input logic [W-1:0] mplr);
        logic [W-1:0] acc;
        logic [W-1:0] q;
        logic [W-1:0] sum;
        logic         guard;
        acc   = '0;
        q     = mplr;
        guard = 1'b0;
        for (int k = 0; k < W; k++) begin
            case ({q[0], guard})
                bsm_pkg::BOOTH_SUB: sum = acc - mcand;
                bsm_pkg::BOOTH_ADD: sum = acc + mcand;
                default:            sum = acc;
            endcase
            guard = q[0];
            q     = {sum[0], q[W-1:1]};
            acc   = {sum[W-1], sum[W-1:1]};
        end
        return bsm_pkg::PROD_W'($signed({acc, q}));
    endfunction

    function automatic logic [W-1:0] pick_operand();
        logic [W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = MOST_NEG;
            1:       v = MOST_POS;
            2:       v = W'($urandom_range(0, 32)) - W'(16);
            3:       v = MOST_NEG ^ W'($urandom_range(0, 255));
            default: v = W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_pair(input logic [W-1:0] mcand, input logic [W-1:0] mplr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bsm_pkg::IN_W'(mplr), bsm_pkg::IN_W'(mcand)};
        do @(posedge aclk); while (!s_tready);
        pending_products.push_back(booth_product(mcand, mplr));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_products.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_pair('0, '0);
        send_pair(W'(1), W'(1));
        send_pair(ALL_ONES, ALL_ONES);
        send_pair(ALL_ONES, W'(1));
        send_pair(MOST_POS, MOST_POS);
        send_pair(MOST_NEG, MOST_NEG);
        send_pair(MOST_NEG, MOST_POS);
        send_pair(MOST_POS, MOST_NEG);
        send_pair(MOST_NEG, ALL_ONES);
        send_pair(ALL_ONES, MOST_NEG);
        send_pair(MOST_NEG, W'(1));
        send_pair(W'(1), MOST_NEG);
        send_pair(MOST_NEG, '0);
        send_pair('0, MOST_NEG);
        send_pair(MOST_POS, ALL_ONES);
        send_pair({(W/2){2'b10}}, {(W/2){2'b01}});
        send_pair({(W/2){2'b01}}, {(W/2){2'b10}});
        send_pair({(W/2){2'b10}}, {(W/2){2'b10}});
        send_pair(W'(2), -W'(3));
        send_pair(-W'(7), W'(5));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_pair(pick_operand(), pick_operand());
        wait_drained();
    endtask

    // receiver stalls long enough for the pipeline to fill and block the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 4 * W;
        repeat (3 * W) send_pair(pick_operand(), pick_operand());
        wait_drained();
    endtask

    // output side: random ready, or a held-off stretch counted down here
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready    <= 1'b0;
                hold_cycles  = hold_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_products.size() == 0) begin
                $error("product: expected none, actual %h", m_tdata);
                mismatch_count++;
            end else begin
                if (m_tdata !== pending_products[0]) begin
                    $error("product: expected %h, actual %h", pending_products[0], m_tdata);
                    mismatch_count++;
                end
                void'(pending_products.pop_front());
            end
        end
    end

    initial begin
        #200us;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(150, 38, 66);
        test_random(150, 66, 38);
        test_random(150, 0, 0);
        test_backpressure();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_products.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
src/bsm_pkg.sv
src/booth_signed_multiplier.sv
src/bsm_checker.sv
verif/tb_booth_signed_multiplier.sv
